FILE: hdl/dthd_pkg.sv
// Package with shared types, codes and constants of the DER TLV header decoder.
`timescale 1ns / 1ps
package dthd_pkg;

  localparam int MAX_LENGTH_BYTES = 8;
  localparam int AVAILABLE_BITS = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

  localparam logic [7:0] LONG_FORM_BIT = 8'h80;
  localparam logic [7:0] LENGTH_COUNT_MASK = 8'h7F;

  localparam logic [2:0] KIND_CONTEXT = 3'd0;
  localparam logic [2:0] KIND_BITSTRING = 3'd1;
  localparam logic [2:0] KIND_OCTETSTRING = 3'd2;
  localparam logic [2:0] KIND_NULL = 3'd3;
  localparam logic [2:0] KIND_OBJECT = 3'd4;
  localparam logic [2:0] KIND_SEQUENCE = 3'd5;
  localparam logic [2:0] KIND_NONE = 3'd6;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_HDR_TRUNC = 3'd2;
  localparam logic [2:0] ST_BAD_TAG = 3'd3;
  localparam logic [2:0] ST_LEN_WIDE = 3'd4;
  localparam logic [2:0] ST_CONTENT_TRUNC = 3'd5;

  localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;
  localparam logic [1:0] CLASS_CONTEXT = 2'd2;

  localparam logic [4:0] TAG_BITSTRING = 5'd3;
  localparam logic [4:0] TAG_OCTETSTRING = 5'd4;
  localparam logic [4:0] TAG_NULL = 5'd5;
  localparam logic [4:0] TAG_OBJECT = 5'd6;
  localparam logic [4:0] TAG_SEQUENCE = 5'd16;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST_LEN,
    PH_LONG_LEN
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        item_start;
    logic [31:0] bytes_available;
  } req_t;

  typedef struct packed {
    logic [1:0]  tag_class;
    logic [4:0]  tag_number;
    logic [2:0]  item_kind;
    logic [3:0]  header_length;
    logic [63:0] content_length;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [1:0]                tag_class;
    logic [4:0]                tag_number;
    logic [2:0]                item_kind;
    logic [3:0]                header_length;
    logic [63:0]               content_length;
    logic [2:0]                status;
    logic                      check;
    logic [AVAILABLE_BITS-1:0] avail;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  function automatic logic [2:0] kind_of(input logic [7:0] t);
    logic [2:0] k;
    k = KIND_NONE;
    if (t[7:6] == CLASS_CONTEXT) begin
      k = KIND_CONTEXT;
    end else if (t[7:6] == CLASS_UNIVERSAL) begin
      case (t[4:0])
        TAG_BITSTRING:   k = KIND_BITSTRING;
        TAG_OCTETSTRING: k = KIND_OCTETSTRING;
        TAG_NULL:        k = KIND_NULL;
        TAG_OBJECT:      k = KIND_OBJECT;
        TAG_SEQUENCE:    k = KIND_SEQUENCE;
        default:         k = KIND_NONE;
      endcase
    end
    return k;
  endfunction

endpackage

FILE: hdl/dthd_front.sv
// Front end: takes element bytes, parses tag and length, and queues header requests.
`timescale 1ns / 1ps
module dthd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  dthd_pkg::req_t req_data,
  output dthd_pkg::push_t push
);
  import dthd_pkg::*;

  phase_t                    phase, phase_next;
  logic [7:0]                tag_byte, tag_byte_next;
  logic [LEN_CNT_W-1:0]      length_bytes_left, length_bytes_left_next;
  logic [LEN_CNT_W-1:0]      length_byte_count, length_byte_count_next;
  logic [63:0]               length_accumulator, length_accumulator_next;
  logic [AVAILABLE_BITS-1:0] available_count, available_count_next;
  logic                      accept;
  logic [6:0]                n;
  logic [2:0]                kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tag_byte <= '0;
      length_bytes_left <= '0;
      length_byte_count <= '0;
      length_accumulator <= '0;
      available_count <= '0;
    end else begin
      phase <= phase_next;
      tag_byte <= tag_byte_next;
      length_bytes_left <= length_bytes_left_next;
      length_byte_count <= length_byte_count_next;
      length_accumulator <= length_accumulator_next;
      available_count <= available_count_next;
    end
  end

  always_comb begin
    accept = req_valid && !req_stall;
    n = 7'(req_data.data_byte & LENGTH_COUNT_MASK);
    kind = kind_of(tag_byte);
    phase_next = phase;
    tag_byte_next = tag_byte;
    length_bytes_left_next = length_bytes_left;
    length_byte_count_next = length_byte_count;
    length_accumulator_next = length_accumulator;
    available_count_next = available_count;
    push = '0;
    push.entry.tag_class = tag_byte[7:6];
    push.entry.tag_number = tag_byte[4:0];
    push.entry.item_kind = KIND_NONE;
    push.entry.status = ST_OK;
    push.entry.avail = available_count;
    if (accept) begin
      if (req_data.item_start) begin
        available_count_next = req_data.bytes_available[AVAILABLE_BITS-1:0];
        tag_byte_next = req_data.data_byte;
        length_bytes_left_next = '0;
        length_byte_count_next = '0;
        length_accumulator_next = '0;
        if (req_data.bytes_available[AVAILABLE_BITS-1:0] < AVAILABLE_BITS'(2)) begin
          push.push = 1'b1;
          push.entry.tag_class = '0;
          push.entry.tag_number = '0;
          push.entry.status = ST_TOO_SHORT;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_FIRST_LEN;
        end
      end else begin
        unique case (phase)
          PH_FIRST_LEN: begin
            push.push = 1'b1;
            phase_next = PH_IDLE;
            if ((req_data.data_byte & LONG_FORM_BIT) == 8'h00) begin
              if (kind == KIND_NONE) begin
                push.entry.status = ST_BAD_TAG;
              end else begin
                push.entry.item_kind = kind;
                push.entry.header_length = 4'd2;
                push.entry.content_length = 64'(req_data.data_byte);
                push.entry.check = 1'b1;
              end
            end else if (AVAILABLE_BITS'(n) + AVAILABLE_BITS'(2) > available_count) begin
              push.entry.status = ST_HDR_TRUNC;
            end else if (kind == KIND_NONE) begin
              push.entry.status = ST_BAD_TAG;
            end else if (n > 7'(MAX_LENGTH_BYTES)) begin
              push.entry.item_kind = kind;
              push.entry.status = ST_LEN_WIDE;
            end else if (n == 7'd0) begin
              push.entry.item_kind = kind;
              push.entry.header_length = 4'd2;
              push.entry.check = 1'b1;
            end else begin
              push.push = 1'b0;
              length_bytes_left_next = LEN_CNT_W'(n);
              length_byte_count_next = LEN_CNT_W'(n);
              length_accumulator_next = '0;
              phase_next = PH_LONG_LEN;
            end
          end
          PH_LONG_LEN: begin
            length_accumulator_next = {length_accumulator[55:0], req_data.data_byte};
            length_bytes_left_next = length_bytes_left - LEN_CNT_W'(1);
            if (length_bytes_left == LEN_CNT_W'(1)) begin
              push.push = 1'b1;
              push.entry.item_kind = kind;
              push.entry.header_length = 4'd2 + 4'(length_byte_count);
              push.entry.content_length = {length_accumulator[55:0], req_data.data_byte};
              push.entry.check = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push.push |-> (req_valid && !req_stall))
    else $error("Header request queued without an accepted byte.");

  a_long_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LONG_LEN) |-> (length_bytes_left != '0))
    else $error("Long length phase with no length bytes left.");

  a_start_enters_len: assert property (@(posedge clk) disable iff (rst)
    (accept && req_data.item_start && !push.push) |=> (phase == PH_FIRST_LEN))
    else $error("Element start did not enter the length phase.");

endmodule

FILE: hdl/dthd_queue.sv
// Short queue of header requests between the front end and the back end.
`timescale 1ns / 1ps
module dthd_queue (
  input  logic            clk,
  input  logic            rst,
  input  dthd_pkg::push_t push,
  input  logic            pop,
  output logic            full,
  output dthd_pkg::head_t head
);
  import dthd_pkg::*;

  entry_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_pop;

  assign full = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push.push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (!push.push && do_pop) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.push |-> (!full || do_pop))
    else $error("Request pushed into a full queue.");

endmodule

FILE: hdl/dthd_back.sv
// Back end: final content length check and the registered result output.
`timescale 1ns / 1ps
module dthd_back (
  input  logic            clk,
  input  logic            rst,
  input  dthd_pkg::head_t head,
  output logic            pop,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output dthd_pkg::rsp_t  rsp_data
);
  import dthd_pkg::*;

  rsp_t        result;
  logic        load;
  logic [64:0] total;
  logic        trunc;

  always_comb begin
    total = {1'b0, head.entry.content_length} + 65'(head.entry.header_length);
    trunc = head.entry.check && (total > 65'(head.entry.avail));
    result.tag_class = head.entry.tag_class;
    result.tag_number = head.entry.tag_number;
    result.item_kind = head.entry.item_kind;
    result.header_length = head.entry.header_length;
    result.content_length = trunc ? 64'd0 : head.entry.content_length;
    result.status = trunc ? ST_CONTENT_TRUNC : head.entry.status;
    load = !rsp_valid || !rsp_stall;
    pop = load && head.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp_data <= result;
    end
  end

  a_trunc_zero_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status == ST_CONTENT_TRUNC) |-> (rsp_data.content_length == 64'd0))
    else $error("Truncated content reported with a nonzero length.");

endmodule

FILE: hdl/der_tlv_header_decoder_core.sv
// Top level of the DER TLV header decoder: front end, request queue and back end.
// Throughput: one byte per cycle unless the queue is full; one header result per element.
// The last header byte queues a request; the output register loads it when not stalled.
// The two-entry request queue plus the output register absorb output stalls.
// Synchronous active-high reset returns the parser to idle and empties the queue.
`timescale 1ns / 1ps
module der_tlv_header_decoder_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dthd_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dthd_pkg::rsp_t rsp_data
);
  import dthd_pkg::*;

  push_t push;
  head_t head;
  logic  full;
  logic  pop;

  assign req_stall = full;

  dthd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .push      (push)
  );

  dthd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  dthd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
